/* hdl/xrr_pkg.sv */
// ----------------------------------------------------------------------------
// xrr_pkg: shared definitions for the xorshift128 ranged random core
// Holds the generator constants, operation codes, state encoding, the
// divider request bundle and the xorshift128 step function.
// ----------------------------------------------------------------------------
package xrr_pkg;

	localparam logic [31:0] INIT_X       = 32'd123456789;
	localparam logic [31:0] INIT_Y       = 32'd362436069;
	localparam logic [31:0] INIT_Z       = 32'd521288629;
	localparam logic [31:0] SEED_DEFAULT = 32'd88675123;
	localparam logic [31:0] LOW31_MASK   = 32'h7fffffff;
	localparam logic [31:0] FRAC_MASK    = 32'h007fffff;

	// Number of restoring steps, one per bit of the 31-bit dividend.
	localparam int unsigned DIV_STEPS = 31;
	localparam int unsigned DIV_CNT_W = $clog2(DIV_STEPS);

	typedef enum logic [1:0] {
		OP_RAW     = 2'd0,
		OP_UPTO    = 2'd1,
		OP_BETWEEN = 2'd2,
		OP_FRAC    = 2'd3
	} op_t;

	typedef enum logic [2:0] {
		ST_IDLE = 3'b001,
		ST_DIV  = 3'b010,
		ST_DONE = 3'b100
	} state_t;

	typedef struct packed {
		logic        start;
		logic [30:0] dividend;
		logic [32:0] divisor;
	} div_req_t;

	typedef struct packed {
		logic        done;
		logic [30:0] remainder;
	} div_rsp_t;

	// New w word from the current x and w state words.
	function automatic logic [31:0] next_w(input logic [31:0] x, input logic [31:0] w);
		logic [31:0] t;
		t = x ^ (x << 11);
		return (w ^ (w >> 19)) ^ (t ^ (t >> 8));
	endfunction

endpackage

/* hdl/xrr_div.sv */
// ----------------------------------------------------------------------------
// xrr_div: iterative restoring remainder unit
// Reduces a 31-bit dividend modulo a 33-bit divisor, one bit per cycle,
// with a single shared subtract-and-compare stage.
// ----------------------------------------------------------------------------
module xrr_div (
	input  logic              clk,
	input  logic              arst_n,
	input  xrr_pkg::div_req_t req,
	output xrr_pkg::div_rsp_t rsp
);

	logic                          busy_q;
	logic                          done_q;
	logic [xrr_pkg::DIV_CNT_W-1:0] cnt_q;
	logic [30:0]                   rem_q;
	logic [30:0]                   dvd_q;
	logic [32:0]                   dvs_q;
	logic [32:0]                   trial;
	logic [32:0]                   diff;
	logic                          fits;

	// Bring down the next dividend bit and try to subtract the divisor.
	assign trial = {1'b0, rem_q, dvd_q[30]};
	assign fits  = (trial >= dvs_q);
	assign diff  = trial - dvs_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				if (cnt_q == xrr_pkg::DIV_CNT_W'(xrr_pkg::DIV_STEPS - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
				cnt_q <= cnt_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			rem_q <= '0;
			dvd_q <= req.dividend;
			dvs_q <= req.divisor;
		end else if (busy_q) begin
			// A partial remainder never exceeds the dividend prefix, so 31 bits hold it.
			rem_q <= fits ? diff[30:0] : trial[30:0];
			dvd_q <= {dvd_q[29:0], 1'b0};
		end
	end

	assign rsp.done      = done_q;
	assign rsp.remainder = rem_q;

endmodule

/* hdl/xorshift128_ranged_random_core.sv */
// ----------------------------------------------------------------------------
// xorshift128_ranged_random_core: xorshift128 generator with ranged output
// Each request advances the 128-bit state once and returns one value.
// ----------------------------------------------------------------------------
// Usage:
// A request enters on in_valid while in_stall is low and carries operation,
// low_bound and high_bound. The result leaves on out_valid with value and
// range_error, and is held while out_stall is high.
// Raw and fraction requests, and ranged requests with an empty span, skip the
// remainder unit and go straight to the output register. Ranged requests with
// a valid span first wait while the remainder unit retires one dividend bit
// per cycle; the remainder is then registered as the result.
// One request is in work at a time; in_stall stays high until its result is
// placed in the output register. If the receiver stalls with the output
// register full, the finished result waits inside the core and in_stall stays high.
// The seed is written on cfg_valid/cfg_ready while no request is in work, and
// a pending write holds in_stall high. It reloads the state, as reset does.
// ----------------------------------------------------------------------------
module xorshift128_ranged_random_core (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [1:0]  operation,
	input  logic [31:0] low_bound,
	input  logic [31:0] high_bound,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [31:0] value,
	output logic        range_error,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [31:0] seed
);

	xrr_pkg::state_t   state_q;
	xrr_pkg::op_t      op_in;
	xrr_pkg::op_t      op_q;
	xrr_pkg::div_req_t div_req;
	xrr_pkg::div_rsp_t div_rsp;

	logic [31:0] x_q, y_q, z_q, w_q;
	logic [31:0] w_new;
	logic [31:0] lo_q;
	logic        err_q;
	logic [33:0] lo_ext, hi_ext, span;
	logic        span_bad;
	logic        ranged;
	logic        accept;
	logic        cfg_write;
	logic        out_free;
	logic        out_valid_q;
	logic [31:0] value_q;
	logic        range_error_q;
	logic [31:0] result;

	assign op_in     = xrr_pkg::op_t'(operation);
	assign accept    = in_valid && !in_stall;
	assign cfg_write = cfg_valid && cfg_ready;
	// A seed write takes the idle cycle, so no request is taken alongside it.
	assign in_stall  = (state_q != xrr_pkg::ST_IDLE) || cfg_valid;
	assign cfg_ready = (state_q == xrr_pkg::ST_IDLE);
	assign out_free  = !out_valid_q || !out_stall;

	assign w_new = xrr_pkg::next_w(x_q, w_q);

	// Exact span, wide enough that no bound pair can wrap it.
	assign lo_ext = {{2{low_bound[31]}}, low_bound};
	assign hi_ext = {{2{high_bound[31]}}, high_bound};
	always_comb begin
		case (op_in)
			xrr_pkg::OP_UPTO:    span = hi_ext + 34'd1;
			xrr_pkg::OP_BETWEEN: span = hi_ext + 34'd1 - lo_ext;
			default:             span = 34'd1;
		endcase
	end
	assign span_bad = span[33] || (span == 34'd0);
	assign ranged   = (op_in == xrr_pkg::OP_UPTO) || (op_in == xrr_pkg::OP_BETWEEN);

	assign div_req.start    = accept && ranged && !span_bad;
	assign div_req.dividend = w_new[30:0];
	assign div_req.divisor  = span[32:0];

	xrr_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= xrr_pkg::ST_IDLE;
			x_q     <= xrr_pkg::INIT_X;
			y_q     <= xrr_pkg::INIT_Y;
			z_q     <= xrr_pkg::INIT_Z;
			w_q     <= xrr_pkg::SEED_DEFAULT;
		end else begin
			case (state_q)
				xrr_pkg::ST_IDLE: begin
					if (cfg_write) begin
						x_q <= xrr_pkg::INIT_X;
						y_q <= xrr_pkg::INIT_Y;
						z_q <= xrr_pkg::INIT_Z;
						w_q <= ($signed(seed) <= 32'sd0) ? xrr_pkg::SEED_DEFAULT : seed;
					end else if (accept) begin
						x_q <= y_q;
						y_q <= z_q;
						z_q <= w_q;
						w_q <= w_new;
						state_q <= div_req.start ? xrr_pkg::ST_DIV : xrr_pkg::ST_DONE;
					end
				end
				xrr_pkg::ST_DIV: begin
					if (div_rsp.done) begin
						state_q <= xrr_pkg::ST_DONE;
					end
				end
				xrr_pkg::ST_DONE: begin
					if (out_free) begin
						state_q <= xrr_pkg::ST_IDLE;
					end
				end
				default: begin
					state_q <= xrr_pkg::ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			op_q  <= op_in;
			lo_q  <= low_bound;
			err_q <= ranged && span_bad;
		end
	end

	always_comb begin
		case (op_q)
			xrr_pkg::OP_RAW:     result = w_q;
			xrr_pkg::OP_UPTO:    result = err_q ? 32'd0 : {1'b0, div_rsp.remainder};
			xrr_pkg::OP_BETWEEN: result = err_q ? 32'd0 : lo_q + {1'b0, div_rsp.remainder};
			xrr_pkg::OP_FRAC:    result = w_q & xrr_pkg::FRAC_MASK;
			default:             result = 32'd0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (state_q == xrr_pkg::ST_DONE && out_free) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == xrr_pkg::ST_DONE && out_free) begin
			value_q       <= result;
			range_error_q <= err_q;
		end
	end

	assign out_valid   = out_valid_q;
	assign value       = value_q;
	assign range_error = range_error_q;

endmodule
